// ----- rtl/thermal_palette_mapper_defines.svh -----
`ifndef THERMAL_PALETTE_MAPPER_DEFINES_SVH
`define THERMAL_PALETTE_MAPPER_DEFINES_SVH

// same-cycle implication
`define TPM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication failed");

// next-cycle implication
`define TPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ----- rtl/tpm_pkg.sv -----
`timescale 1ns / 1ps

package tpm_pkg;

   localparam int WAYPOINT_COUNT = 6;
   localparam int SEG_COUNT      = WAYPOINT_COUNT - 1;
   localparam int SEG_W          = (SEG_COUNT > 1) ? $clog2(SEG_COUNT) : 1;
   localparam int WP_W           = $clog2(WAYPOINT_COUNT);
   localparam int CH_COUNT       = 3;

   localparam int RAW_W          = 16;
   localparam int CH_W           = 8;
   localparam int NUM_W          = RAW_W + CH_W;
   localparam int RECIP_SHIFT    = 24;
   localparam int RECIP_W        = RECIP_SHIFT + 1;
   localparam int PROD_W         = RECIP_W + NUM_W;
   localparam int MIX_W          = 2 * CH_W;

   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = 1;
   localparam int QCNT_W         = 2;

   localparam int ADDR_W         = 3;
   localparam int DATA_W         = 32;
   localparam logic [ADDR_W-3:0] REG_PALETTE_MODE = '0;

   localparam logic [CH_W-1:0] CH_MAX = '1;

   typedef enum logic {
      MODE_GRAY = 1'b0,
      MODE_IRON = 1'b1
   } palette_mode_type;

   typedef struct packed {
      logic [RAW_W-1:0] pixel_raw;
      logic             frame_end_in;
   } tpm_req_type;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end_out;
   } tpm_rsp_type;

   typedef struct packed {
      logic             gray;
      logic [CH_W-1:0]  gray_level;
      logic [SEG_W-1:0] seg;
      logic [RAW_W-1:0] offset;
      logic             frame_end;
   } tpm_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tpm_q_status_type;

   typedef logic [RAW_W-1:0]   level_tab_type [WAYPOINT_COUNT];
   typedef logic [CH_W-1:0]    color_tab_type [CH_COUNT][WAYPOINT_COUNT];
   typedef logic [RAW_W-1:0]   span_tab_type  [SEG_COUNT];
   typedef logic [RECIP_W-1:0] recip_tab_type [SEG_COUNT];

   localparam level_tab_type WP_LEVEL = '{
      16'd29500, 16'd29900, 16'd30300, 16'd30700, 16'd31100, 16'd31500
   };

   // red, green, blue rows
   localparam color_tab_type WP_COLOR = '{
      '{8'd0,  8'd0,   8'd180, 8'd255, 8'd255, 8'd255},
      '{8'd0,  8'd0,   8'd0,   8'd0,   8'd200, 8'd255},
      '{8'd80, 8'd200, 8'd100, 8'd0,   8'd0,   8'd255}
   };

   function automatic span_tab_type make_span();
      span_tab_type s;
      for (int k = 0; k < SEG_COUNT; k++) begin
         s[k] = WP_LEVEL[k+1] - WP_LEVEL[k];
      end
      return s;
   endfunction

   localparam span_tab_type SEG_SPAN = make_span();

   // floor(2^RECIP_SHIFT / span) per segment
   localparam recip_tab_type SEG_RECIP = '{
      RECIP_W'((64'd1 << RECIP_SHIFT) / SEG_SPAN[0]),
      RECIP_W'((64'd1 << RECIP_SHIFT) / SEG_SPAN[1]),
      RECIP_W'((64'd1 << RECIP_SHIFT) / SEG_SPAN[2]),
      RECIP_W'((64'd1 << RECIP_SHIFT) / SEG_SPAN[3]),
      RECIP_W'((64'd1 << RECIP_SHIFT) / SEG_SPAN[4])
   };

endpackage

// ----- rtl/tpm_front.sv -----
`timescale 1ns / 1ps

module tpm_front (
   input  logic                       clock,
   input  logic                       reset,
   input  tpm_pkg::palette_mode_type  mode,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tpm_pkg::tpm_req_type       req_payload,
   input  tpm_pkg::tpm_q_status_type  q_status,
   output logic                       push,
   output tpm_pkg::tpm_item_type      push_item
);
   import tpm_pkg::*;

   logic             hold_v_ff;
   tpm_item_type     hold_item_ff;
   tpm_item_type     item_in;
   logic [RAW_W-1:0] raw;
   logic [SEG_W-1:0] seg;

   assign req_ready = !hold_v_ff || !q_status.full;
   assign push      = hold_v_ff && !q_status.full;
   assign push_item = hold_item_ff;

   // segment search and offset from its lower waypoint
   always_comb begin
      raw = req_payload.pixel_raw;
      seg = SEG_W'(SEG_COUNT - 1);
      for (int k = SEG_COUNT - 1; k >= 0; k--) begin
         if (raw <= WP_LEVEL[k+1]) begin
            seg = SEG_W'(k);
         end
      end
      item_in.gray       = (mode == MODE_GRAY);
      item_in.gray_level = raw[RAW_W-1 -: CH_W];
      item_in.frame_end  = req_payload.frame_end_in;
      priority if (raw <= WP_LEVEL[0]) begin
         item_in.seg    = '0;
         item_in.offset = '0;
      end else if (raw >= WP_LEVEL[WAYPOINT_COUNT-1]) begin
         item_in.seg    = SEG_W'(SEG_COUNT - 1);
         item_in.offset = SEG_SPAN[SEG_COUNT-1];
      end else begin
         item_in.seg    = seg;
         item_in.offset = raw - WP_LEVEL[WP_W'(seg)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_v_ff <= 1'b0;
      end else if (req_ready) begin
         hold_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         hold_item_ff <= item_in;
      end
   end

endmodule

// ----- rtl/tpm_queue.sv -----
`timescale 1ns / 1ps

module tpm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  tpm_pkg::tpm_item_type      push_item,
   input  logic                       pop,
   output tpm_pkg::tpm_item_type      pop_item,
   output tpm_pkg::tpm_q_status_type  q_status
);
   import tpm_pkg::*;

   tpm_item_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_item       = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/tpm_back.sv -----
`timescale 1ns / 1ps

module tpm_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tpm_pkg::tpm_q_status_type  q_status,
   output logic                       pop,
   input  tpm_pkg::tpm_item_type      pop_item,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tpm_pkg::tpm_rsp_type       rsp_payload
);
   import tpm_pkg::*;

   typedef struct packed {
      logic            gray;
      logic [CH_W-1:0] gray_level;
      logic            frame_end;
   } tag_type;

   typedef struct packed {
      tag_type           tag;
      logic [SEG_W-1:0]  seg;
      logic [NUM_W-1:0]  num;
      logic [PROD_W-1:0] prod;
   } s1_type;

   typedef struct packed {
      tag_type          tag;
      logic [SEG_W-1:0] seg;
      logic [CH_W-1:0]  q_est;
      logic [NUM_W-1:0] rem;
   } s2_type;

   typedef struct packed {
      tag_type          tag;
      logic [SEG_W-1:0] seg;
      logic [CH_W-1:0]  t;
   } s3_type;

   typedef struct packed {
      tag_type                         tag;
      logic [CH_COUNT-1:0][MIX_W-1:0]  mix;
   } s4_type;

   logic        advance;
   logic [3:0]  v_ff;
   logic        out_v_ff;
   s1_type      s1_ff, s1_in;
   s2_type      s2_ff, s2_in;
   s3_type      s3_ff, s3_in;
   s4_type      s4_ff, s4_in;
   tpm_rsp_type rsp_ff, rsp_in;
   logic [RAW_W-1:0] span2;
   logic [RAW_W-1:0] span3;
   logic [WP_W-1:0]  wp_lo;
   logic [WP_W-1:0]  wp_hi;
   logic [CH_COUNT-1:0][CH_W-1:0] chan;
   logic [MIX_W-1:0] rounded [CH_COUNT];

   assign advance     = !out_v_ff || rsp_ready;
   assign pop         = advance && !q_status.empty;
   assign rsp_valid   = out_v_ff;
   assign rsp_payload = rsp_ff;

   // offset * 255, then times the segment reciprocal
   always_comb begin
      s1_in.tag.gray       = pop_item.gray;
      s1_in.tag.gray_level = pop_item.gray_level;
      s1_in.tag.frame_end  = pop_item.frame_end;
      s1_in.seg            = pop_item.seg;
      s1_in.num  = {pop_item.offset, CH_W'(0)} - NUM_W'(pop_item.offset);
      s1_in.prod = PROD_W'(s1_in.num) * PROD_W'(SEG_RECIP[pop_item.seg]);
   end

   // quotient estimate and remainder
   always_comb begin
      span2        = SEG_SPAN[s1_ff.seg];
      s2_in.tag    = s1_ff.tag;
      s2_in.seg    = s1_ff.seg;
      s2_in.q_est  = s1_ff.prod[RECIP_SHIFT +: CH_W];
      s2_in.rem    = s1_ff.num - NUM_W'(NUM_W'(s2_in.q_est) * NUM_W'(span2));
   end

   // one correction step gives the weight
   always_comb begin
      span3     = SEG_SPAN[s2_ff.seg];
      s3_in.tag = s2_ff.tag;
      s3_in.seg = s2_ff.seg;
      s3_in.t   = s2_ff.q_est
                + CH_W'((s2_ff.rem >= NUM_W'(span3)) && (span3 != '0));
   end

   // a*(255-t) + b*t per channel
   always_comb begin
      wp_lo     = WP_W'(s3_ff.seg);
      wp_hi     = wp_lo + WP_W'(1);
      s4_in.tag = s3_ff.tag;
      for (int c = 0; c < CH_COUNT; c++) begin
         s4_in.mix[c] = MIX_W'(MIX_W'(WP_COLOR[c][wp_lo]) * MIX_W'(CH_MAX - s3_ff.t))
                      + MIX_W'(MIX_W'(WP_COLOR[c][wp_hi]) * MIX_W'(s3_ff.t));
      end
   end

   // divide by 255 as (x + (x >> 8) + 1) >> 8
   always_comb begin
      for (int c = 0; c < CH_COUNT; c++) begin
         rounded[c] = s4_ff.mix[c] + (s4_ff.mix[c] >> CH_W) + MIX_W'(1);
         if (s4_ff.tag.gray) begin
            chan[c] = s4_ff.tag.gray_level;
         end else begin
            chan[c] = rounded[c][MIX_W-1 -: CH_W];
         end
      end
      rsp_in.red           = chan[0];
      rsp_in.green         = chan[1];
      rsp_in.blue          = chan[2];
      rsp_in.frame_end_out = s4_ff.tag.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (advance) begin
         v_ff     <= {v_ff[2:0], pop};
         out_v_ff <= v_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         rsp_ff <= rsp_in;
      end
   end

endmodule

// ----- rtl/thermal_palette_mapper.sv -----
// Thermal pixel colorizer. Each request carries one 16-bit raw pixel and an end-of-frame
// flag and yields one 8-bit red, green, blue response in request order, with the flag
// copied. Register palette_mode at byte address 0 selects grayscale (0, the reset value,
// high byte on all channels) or the fixed six-waypoint iron ramp (1); write it only while
// no request is in flight. The block takes one request every cycle and returns one
// response every cycle for as long as the response side is ready; that figure is set by
// the back pipeline, which moves all its stages together. When nothing stalls, an accepted
// request is registered in the front classifier, written into the two-entry queue and then
// passes the back pipeline registers (reciprocal multiply, remainder, correction, channel
// blend, and divide by 255 into the output register) before its response is offered.
`timescale 1ns / 1ps
`include "thermal_palette_mapper_defines.svh"

module thermal_palette_mapper (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  tpm_pkg::tpm_req_type         req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output tpm_pkg::tpm_rsp_type         rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tpm_pkg::ADDR_W-1:0]   paddr,
   input  logic [tpm_pkg::DATA_W-1:0]   pwdata,
   output logic [tpm_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);
   import tpm_pkg::*;

   palette_mode_type mode_ff;
   palette_mode_type mode_in;
   logic             reg_hit;
   logic             q_push;
   logic             q_pop;
   tpm_item_type     q_push_item;
   tpm_item_type     q_pop_item;
   tpm_q_status_type q_status;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[ADDR_W-1:2] == REG_PALETTE_MODE);

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         mode_in = palette_mode_type'(pwdata[0]);
      end
      if (reg_hit) begin
         prdata = DATA_W'(mode_ff);
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GRAY;
      end else begin
         mode_ff <= mode_in;
      end
   end

   tpm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (q_push),
      .push_item   (q_push_item)
   );

   tpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .q_status  (q_status)
   );

   tpm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .pop         (q_pop),
      .pop_item    (q_pop_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `TPM_ASSERT_IMPLY(a_push_not_full, clock, reset, q_push, !q_status.full)
   `TPM_ASSERT_IMPLY(a_pop_not_empty, clock, reset, q_pop, !q_status.empty)
   `TPM_ASSERT_NEXT(a_queue_drains, clock, reset, q_status.full && q_pop && !q_push, !q_status.full)

endmodule

// ----- bench/thermal_palette_mapper_tb.sv -----
`timescale 1ns / 1ps

module thermal_palette_mapper_tb;
   import tpm_pkg::*;

   localparam logic [ADDR_W-1:0] MODE_ADDR     = {REG_PALETTE_MODE, 2'b00};
   localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
   localparam int PHASE_COUNT      = 6;
   localparam int PIXELS_PER_PHASE = 150;
   localparam int IDLE_LIMIT       = 1000;
   localparam int TAIL_CYCLES      = 20;

   localparam int unsigned IRON_LEVEL [6] = '{29500, 29900, 30300, 30700, 31100, 31500};
   localparam int unsigned IRON_RED   [6] = '{0,   0,   180, 255, 255, 255};
   localparam int unsigned IRON_GREEN [6] = '{0,   0,   0,   0,   200, 255};
   localparam int unsigned IRON_BLUE  [6] = '{80,  200, 100, 0,   0,   255};

   typedef struct packed {
      logic              wr_cfg;
      logic [ADDR_W-1:0] cfg_addr;
      logic [31:0]       cfg_data;
      tpm_req_type       px;
      logic              known;
      tpm_rsp_type       want;
   } pixel_case_type;

   localparam int CASE_COUNT = 22;
   localparam pixel_case_type DIRECTED_CASES [CASE_COUNT] = '{
      '{1'b0, MODE_ADDR, 32'd0, '{16'h0000, 1'b0}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b0}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'hFFFF, 1'b1}, 1'b1, '{8'hFF, 8'hFF, 8'hFF, 1'b1}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'h8000, 1'b0}, 1'b1, '{8'h80, 8'h80, 8'h80, 1'b0}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'h00FF, 1'b1}, 1'b1, '{8'h00, 8'h00, 8'h00, 1'b1}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'h7F01, 1'b0}, 1'b1, '{8'h7F, 8'h7F, 8'h7F, 1'b0}},
      // write to an unmapped address leaves grayscale in place
      '{1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF, '{16'h1234, 1'b0}, 1'b1,
        '{8'h12, 8'h12, 8'h12, 1'b0}},
      // upper data bits set, only bit 0 counts
      '{1'b1, MODE_ADDR, {31'h7FFF_FFFF, MODE_IRON}, '{16'd0, 1'b0}, 1'b1,
        '{8'd0, 8'd0, 8'd80, 1'b0}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd29500, 1'b1}, 1'b1, '{8'd0, 8'd0, 8'd80, 1'b1}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd29501, 1'b0}, 1'b0, '0},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd29900, 1'b0}, 1'b1, '{8'd0, 8'd0, 8'd200, 1'b0}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd29901, 1'b1}, 1'b0, '0},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd30300, 1'b0}, 1'b1, '{8'd180, 8'd0, 8'd100, 1'b0}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd30100, 1'b0}, 1'b0, '0},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd30700, 1'b1}, 1'b1, '{8'd255, 8'd0, 8'd0, 1'b1}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd30900, 1'b0}, 1'b0, '0},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd31100, 1'b0}, 1'b1, '{8'd255, 8'd200, 8'd0, 1'b0}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd31499, 1'b0}, 1'b0, '0},
      '{1'b0, MODE_ADDR, 32'd0, '{16'd31500, 1'b0}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'hFFFF, 1'b1}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
      '{1'b1, MODE_ADDR, {31'h7FFF_FFFF, MODE_GRAY}, '{16'hABCD, 1'b1}, 1'b1,
        '{8'hAB, 8'hAB, 8'hAB, 1'b1}},
      '{1'b0, MODE_ADDR, 32'd0, '{16'h5A5A, 1'b0}, 1'b0, '0},
      '{1'b1, MODE_ADDR, {31'd0, MODE_IRON}, '{16'd30500, 1'b1}, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tpm_req_type       req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tpm_rsp_type       rsp_payload;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   palette_mode_type  mode_shadow = MODE_GRAY;
   tpm_rsp_type       pending_colors [$];
   int                color_mismatches = 0;
   int                burst_left = 0;
   int                idle_cycles = 0;
   int                stall_left = 0;
   int                stall_pct = 0;
   int                ready_cycle = 0;

   thermal_palette_mapper DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [CH_W-1:0] mix_channel(int unsigned a, int unsigned b,
                                                   int unsigned t);
      return CH_W'((a * (255 - t) + b * t) / 255);
   endfunction

   function automatic tpm_rsp_type colorize(tpm_req_type px, palette_mode_type mode);
      tpm_rsp_type c;
      int unsigned raw;
      int unsigned t;
      logic        done;
      raw = px.pixel_raw;
      done = 1'b0;
      c.frame_end_out = px.frame_end_in;
      if (mode == MODE_GRAY) begin
         c.red   = px.pixel_raw[15:8];
         c.green = px.pixel_raw[15:8];
         c.blue  = px.pixel_raw[15:8];
      end else if (raw <= IRON_LEVEL[0]) begin
         c.red   = CH_W'(IRON_RED[0]);
         c.green = CH_W'(IRON_GREEN[0]);
         c.blue  = CH_W'(IRON_BLUE[0]);
      end else if (raw >= IRON_LEVEL[5]) begin
         c.red   = CH_W'(IRON_RED[5]);
         c.green = CH_W'(IRON_GREEN[5]);
         c.blue  = CH_W'(IRON_BLUE[5]);
      end else begin
         for (int k = 0; k < 5; k++) begin
            if (!done && raw <= IRON_LEVEL[k+1]) begin
               t = (raw - IRON_LEVEL[k]) * 255 / (IRON_LEVEL[k+1] - IRON_LEVEL[k]);
               if (t > 255) t = 255;
               c.red   = mix_channel(IRON_RED[k], IRON_RED[k+1], t);
               c.green = mix_channel(IRON_GREEN[k], IRON_GREEN[k+1], t);
               c.blue  = mix_channel(IRON_BLUE[k], IRON_BLUE[k+1], t);
               done = 1'b1;
            end
         end
      end
      return c;
   endfunction

   function automatic logic [RAW_W-1:0] iron_pixel();
      int v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 65535);
         1: v = int'(IRON_LEVEL[$urandom_range(0, 5)]) + $urandom_range(0, 2) - 1;
         default: v = $urandom_range(29300, 31700);
      endcase
      return RAW_W'(v);
   endfunction

   task automatic note_mismatch(input string msg);
      color_mismatches++;
      if (color_mismatches <= 10) $display("%s", msg);
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_pixel(input tpm_req_type px, input logic known,
                             input tpm_rsp_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_colors.push_back(known ? want : colorize(px, mode_shadow));
      @(negedge clock);
   endtask

   task automatic finish_requests();
      req_valid <= 1'b0;
      while (pending_colors.size() > 0) @(posedge clock);
      @(negedge clock);
   endtask

   // write the given address, then read back the mode register
   task automatic program_mode(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (addr == MODE_ADDR) mode_shadow = palette_mode_type'(data[0]);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= MODE_ADDR;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== DATA_W'(mode_shadow))
         note_mismatch($sformatf("mode readback mismatch: expected %0h got %0h",
                                 DATA_W'(mode_shadow), prdata));
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // response stalls, started at a randomly redrawn density of 0, 15 or 50 percent
   always @(negedge clock) begin
      ready_cycle++;
      if (ready_cycle % 128 == 0) begin
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 15;
            default: stall_pct = 50;
         endcase
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 5);
      end
   end

   always @(posedge clock) begin
      tpm_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_colors.size() == 0) begin
            note_mismatch($sformatf("unexpected pixel result r=%0d g=%0d b=%0d fe=%0b",
                                    rsp_payload.red, rsp_payload.green, rsp_payload.blue,
                                    rsp_payload.frame_end_out));
         end else begin
            want = pending_colors.pop_front();
            if (rsp_payload.red !== want.red || rsp_payload.green !== want.green ||
                rsp_payload.blue !== want.blue ||
                rsp_payload.frame_end_out !== want.frame_end_out)
               note_mismatch($sformatf(
                  "pixel mismatch: expected r=%0d g=%0d b=%0d fe=%0b got r=%0d g=%0d b=%0d fe=%0b",
                  want.red, want.green, want.blue, want.frame_end_out,
                  rsp_payload.red, rsp_payload.green, rsp_payload.blue,
                  rsp_payload.frame_end_out));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("thermal_palette_mapper_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      tpm_req_type px;
      logic [31:0] cfg_word;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_CASES[i]) begin
         if (DIRECTED_CASES[i].wr_cfg) begin
            finish_requests();
            program_mode(DIRECTED_CASES[i].cfg_addr, DIRECTED_CASES[i].cfg_data);
         end
         send_pixel(DIRECTED_CASES[i].px, DIRECTED_CASES[i].known, DIRECTED_CASES[i].want);
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         finish_requests();
         if (phase == 3) begin
            program_mode(UNMAPPED_ADDR, $urandom());
            @(negedge clock);
         end
         cfg_word = $urandom();
         cfg_word[0] = phase[0] ? MODE_GRAY : MODE_IRON;
         program_mode(MODE_ADDR, cfg_word);
         for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
            px.pixel_raw    = (mode_shadow == MODE_IRON) ? iron_pixel()
                                                         : RAW_W'($urandom());
            px.frame_end_in = ($urandom_range(0, 15) == 0);
            send_pixel(px, 1'b0, '0);
         end
      end

      finish_requests();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (color_mismatches == 0) begin
         $display("thermal_palette_mapper_tb passed");
      end else begin
         $display("thermal_palette_mapper_tb failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tpm_pkg.sv
rtl/tpm_front.sv
rtl/tpm_queue.sv
rtl/tpm_back.sv
rtl/thermal_palette_mapper.sv
bench/thermal_palette_mapper_tb.sv
